// ----- design/aes_pkg.sv -----
// Package for the AES block cipher: substitution tables and round-step functions.
package aes_pkg;

    localparam int KEY_ROWS = 15;
    localparam int ROW_BITS = 128;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // multiply by a small constant in GF(2^8)
    function automatic logic [7:0] gmul(input logic [3:0] k, input logic [7:0] x);
        logic [7:0] acc;
        logic [7:0] v;
        acc = 8'h00;
        v = x;
        for (int b = 0; b < 4; b++)
        begin
            if (k[b])
                acc = acc ^ v;
            v = xtime(v);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int k = 0; k < 16; k++)
            r[127 - 8 * k -: 8] = inv ? INV_SBOX[s[127 - 8 * k -: 8]] : SBOX[s[127 - 8 * k -: 8]];
        return r;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        int src;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            src = inv ? ((16 + i - 4 * (i % 4)) % 16) : ((i + 4 * (i % 4)) % 16);
            r[127 - 8 * i -: 8] = s[127 - 8 * src -: 8];
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [3:0] m0;
        logic [3:0] m1;
        logic [3:0] m2;
        logic [3:0] m3;
        r = '0;
        m0 = inv ? 4'd14 : 4'd2;
        m1 = inv ? 4'd11 : 4'd3;
        m2 = inv ? 4'd13 : 4'd1;
        m3 = inv ? 4'd9 : 4'd1;
        for (int c = 0; c < 16; c += 4)
            for (int j = 0; j < 4; j++)
                r[127 - 8 * (c + j) -: 8] =
                    gmul(m0, s[127 - 8 * (c + j) -: 8]) ^
                    gmul(m1, s[127 - 8 * (c + (j + 1) % 4) -: 8]) ^
                    gmul(m2, s[127 - 8 * (c + (j + 2) % 4) -: 8]) ^
                    gmul(m3, s[127 - 8 * (c + (j + 3) % 4) -: 8]);
        return r;
    endfunction

endpackage

// ----- design/aes_ram.sv -----
// Generic single-port-write, registered-read RAM.
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/aes_block_cipher.sv -----
// Top level of the AES block cipher: config registers, key expansion and round sequencer.
//
// Usage: write key_length (index 0) and key_part0..3 (indexes 1..4) over the cfg port
// while the block is idle. Any such write invalidates the expanded key schedule.
// Input channel (in_valid/in_stall) carries op, block_hi, block_lo; output channel
// (out_valid/out_stall) returns result_hi, result_lo. A transaction completes when
// valid is high and stall is low.
// Flow: an accepted block waits on the registered read of the round-key store, then
// makes Nr + 1 passes through the shared round unit (Nr = 10, 12 or 14), and then
// moves into the output register.
// The first block after a config write also runs the key expansion first:
// 4 * (Nr + 1) key words, one key word per cycle.
// Blocks do not overlap: in_stall stays high while a block is in flight. The next
// block is taken while a finished result still waits.
// Reset: all control state clears, registers read zero, keys marked not expanded.
// Output stall: the result holds in the output register; a newer finished block
// waits in the work register until the output register frees up.
module aes_block_cipher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         op,
    input  logic [63:0]  block_hi,
    input  logic [63:0]  block_lo,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [63:0]  result_hi,
    output logic [63:0]  result_lo
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] REG_KEY_LAST   = 3'd4;

    localparam int ROW_AW = $clog2(aes_pkg::KEY_ROWS);

    logic [2:0]   state_reg, state_next;
    logic [1:0]   key_length_reg, key_length_next;
    logic [63:0]  key_part_reg [4];
    logic [63:0]  key_part_next [4];
    logic         keys_ready_reg, keys_ready_next;
    logic         op_reg, op_next;
    logic [127:0] data_reg, data_next;
    logic [3:0]   step_reg, step_next;
    logic [5:0]   widx_reg, widx_next;
    logic [2:0]   pos_reg, pos_next;
    logic [7:0]   rc_reg, rc_next;
    logic [31:0]  win_reg [8];
    logic [31:0]  win_next [8];
    logic [95:0]  rowbuf_reg, rowbuf_next;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] result_reg, result_next;

    logic [1:0]   code;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [3:0]   nr_p1;
    logic [5:0]   total;
    logic [63:0]  part;
    logic [31:0]  wnk;
    logic [31:0]  tmp;
    logic [31:0]  new_word;
    logic         ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [ROW_AW-1:0] ram_raddr;
    logic [127:0] ram_rdata;
    logic [3:0]   rd_step;
    logic [127:0] round_out;
    logic [127:0] t_enc;
    logic [127:0] t_dec;
    logic         last_round;

    // code 3 runs as a 256-bit key
    assign code  = (key_length_reg == 2'd3) ? 2'd2 : key_length_reg;
    assign nk    = 4'd4 + {1'b0, code, 1'b0};
    assign nr    = nk + 4'd6;
    assign nr_p1 = nr + 4'd1;
    assign total = {nr_p1, 2'b00};

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result_hi = result_reg[127:64];
    assign result_lo = result_reg[63:0];

    // key expansion, one word per cycle
    always_comb
    begin
        part = key_part_reg[widx_reg[2:1]];
        case (nk)
            4'd4:    wnk = win_reg[3];
            4'd6:    wnk = win_reg[5];
            default: wnk = win_reg[7];
        endcase
        tmp = win_reg[0];
        if (pos_reg == 3'd0)
            tmp = aes_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rc_reg, 24'h0};
        else if (nk == 4'd8 && pos_reg == 3'd4)
            tmp = aes_pkg::sub_word(win_reg[0]);
        if (widx_reg < {2'b00, nk})
            new_word = widx_reg[0] ? part[31:0] : part[63:32];
        else
            new_word = wnk ^ tmp;
    end

    assign ram_we    = (state_reg == ST_EXPAND) && (widx_reg[1:0] == 2'd3);
    assign ram_waddr = widx_reg[5:2];

    // read the row for the step that runs next cycle
    assign rd_step   = (state_reg == ST_RUN && !last_round) ? step_reg + 4'd1 : 4'd0;
    assign ram_raddr = op_reg ? nr - rd_step : rd_step;

    aes_ram #(
        .WIDTH(aes_pkg::ROW_BITS),
        .DEPTH(aes_pkg::KEY_ROWS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data ({rowbuf_reg, new_word}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared round unit
    always_comb
    begin
        last_round = (step_reg == nr);
        t_enc = aes_pkg::shift_rows(aes_pkg::sub_bytes(data_reg, 1'b0), 1'b0);
        t_dec = aes_pkg::sub_bytes(aes_pkg::shift_rows(data_reg, 1'b1), 1'b1) ^ ram_rdata;
        if (step_reg == 4'd0)
            round_out = data_reg ^ ram_rdata;
        else if (!op_reg)
            round_out = (last_round ? t_enc : aes_pkg::mix_columns(t_enc, 1'b0)) ^ ram_rdata;
        else
            round_out = last_round ? t_dec : aes_pkg::mix_columns(t_dec, 1'b1);
    end

    always_comb
    begin
        state_next      = state_reg;
        key_length_next = key_length_reg;
        key_part_next   = key_part_reg;
        keys_ready_next = keys_ready_reg;
        op_next         = op_reg;
        data_next       = data_reg;
        step_next       = step_reg;
        widx_next       = widx_reg;
        pos_next        = pos_reg;
        rc_next         = rc_reg;
        win_next        = win_reg;
        rowbuf_next     = rowbuf_reg;
        out_valid_next  = out_valid_reg;
        result_next     = result_reg;

        // drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_en && cfg_index <= REG_KEY_LAST)
        begin
            keys_ready_next = 1'b0;
            if (cfg_index == REG_KEY_LENGTH)
                key_length_next = cfg_data[1:0];
            else
                key_part_next[cfg_index[1:0] - 2'd1] = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op;
                    data_next = {block_hi, block_lo};
                    step_next = 4'd0;
                    widx_next = 6'd0;
                    pos_next  = 3'd0;
                    rc_next   = 8'h01;
                    state_next = keys_ready_reg ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                win_next[0] = new_word;
                for (int k = 1; k < 8; k++)
                    win_next[k] = win_reg[k - 1];
                rowbuf_next = {rowbuf_reg[63:0], new_word};
                pos_next = (pos_reg == nk[2:0] - 3'd1) ? 3'd0 : pos_reg + 3'd1;
                if (pos_reg == 3'd0 && widx_reg >= {2'b00, nk})
                    rc_next = aes_pkg::xtime(rc_reg);
                if (widx_reg == total - 6'd1)
                begin
                    keys_ready_next = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                    widx_next = widx_reg + 6'd1;
            end
            ST_LOAD:
                state_next = ST_RUN;
            ST_RUN:
            begin
                data_next = round_out;
                if (last_round)
                    state_next = ST_DONE;
                else
                    step_next = step_reg + 4'd1;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    result_next    = data_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_length_reg <= 2'd0;
            for (int k = 0; k < 4; k++)
                key_part_reg[k] <= 64'h0;
            keys_ready_reg <= 1'b0;
            op_reg         <= 1'b0;
            data_reg       <= 128'h0;
            step_reg       <= 4'd0;
            widx_reg       <= 6'd0;
            pos_reg        <= 3'd0;
            rc_reg         <= 8'h01;
            out_valid_reg  <= 1'b0;
            result_reg     <= 128'h0;
        end
        else
        begin
            state_reg      <= state_next;
            key_length_reg <= key_length_next;
            key_part_reg   <= key_part_next;
            keys_ready_reg <= keys_ready_next;
            op_reg         <= op_next;
            data_reg       <= data_next;
            step_reg       <= step_next;
            widx_reg       <= widx_next;
            pos_reg        <= pos_next;
            rc_reg         <= rc_next;
            out_valid_reg  <= out_valid_next;
            result_reg     <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        rowbuf_reg <= rowbuf_next;
    end

    a_run_has_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> keys_ready_reg)
        else $error("round sequencing without an expanded key schedule");

    a_expand_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND) |-> (widx_reg < total))
        else $error("key expansion ran past the schedule length");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= nr))
        else $error("round counter beyond round count");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EXPAND || state_reg == ST_LOAD))
        else $error("accepted transaction did not start work");

endmodule
